### hw/rtl/socks5_client_handshake_top_defines.svh
// Assertion macros shared by the SOCKS5 client handshake RTL.
`ifndef SOCKS5_CLIENT_HANDSHAKE_TOP_DEFINES_SVH
`define SOCKS5_CLIENT_HANDSHAKE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define S5HS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define S5HS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/s5hs_pkg.sv
// Types and constants of the SOCKS5 client handshake.
package s5hs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_METHOD    = 3'd1,
        PH_REPLY     = 3'd2,
        PH_CONNECTED = 3'd3,
        PH_FAILED    = 3'd4
    } phase_t;

    // Kind of result burst handed from the parser to the emitter
    typedef enum logic [1:0] {
        BURST_GREET  = 2'd0,
        BURST_REQ    = 2'd1,
        BURST_STATUS = 2'd2,
        BURST_DATA   = 2'd3
    } burst_t;

    typedef struct packed {
        burst_t     burst;
        logic [7:0] data;
        logic [3:0] status;
    } desc_t;

    localparam logic [1:0] RK_TX     = 2'd0;
    localparam logic [1:0] RK_STATUS = 2'd1;
    localparam logic [1:0] RK_DATA   = 2'd2;

    localparam logic [3:0] ST_CONNECTED = 4'd0;
    localparam logic [3:0] ST_BAD_PROTO = 4'd1;
    localparam logic [3:0] ST_NO_AUTH   = 4'd2;
    localparam logic [3:0] ST_CODE_BASE = 4'd2;
    localparam logic [3:0] ST_UNKNOWN   = 4'd11;

    localparam logic [1:0] CFG_IPV6       = 2'd0;
    localparam logic [1:0] CFG_ADDR_UPPER = 2'd1;
    localparam logic [1:0] CFG_ADDR_LOWER = 2'd2;
    localparam logic [1:0] CFG_PORT       = 2'd3;

    localparam logic [7:0] SOCKS_VER    = 8'h05;
    localparam logic [7:0] CMD_CONNECT  = 8'h01;
    localparam logic [7:0] METHOD_NONE  = 8'h00;
    localparam logic [7:0] METHOD_NONE_OK = 8'hff;
    localparam logic [7:0] ATYP_IPV4    = 8'h01;
    localparam logic [7:0] ATYP_IPV6    = 8'h04;
    localparam logic [7:0] MAX_REPLY_CODE = 8'h08;

    localparam logic [4:0] LEN_REPLY_IPV4 = 5'd10;
    localparam logic [4:0] LEN_REPLY_IPV6 = 5'd22;
    localparam logic [4:0] LEN_REPLY_OTHER = 5'd6;
    localparam logic [4:0] REPLY_HDR_LEN  = 5'd4;

    localparam logic [4:0] LEN_GREET    = 5'd3;
    localparam logic [4:0] LEN_REQ_IPV4 = 5'd10;
    localparam logic [4:0] LEN_REQ_IPV6 = 5'd22;
    localparam logic [4:0] LEN_SINGLE   = 5'd1;

endpackage

### hw/rtl/s5hs_parser.sv
// Handshake parser: protocol state and at most one burst descriptor per transfer.
`include "socks5_client_handshake_top_defines.svh"

module s5hs_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           in_kind,
    input  logic [7:0]     in_byte,
    output logic           desc_valid,
    output s5hs_pkg::desc_t desc
);
    import s5hs_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [4:0] count_reg, count_next;
    logic       vok_reg, vok_next;
    logic [7:0] code_reg, code_next;
    logic [4:0] rlen_reg, rlen_next;

    logic [4:0] count_inc;

    assign count_inc = count_reg + 5'd1;

    // Next protocol state and the burst this transfer causes
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        vok_next    = vok_reg;
        code_next   = code_reg;
        rlen_next   = rlen_reg;
        desc_valid  = 1'b0;
        desc.burst  = BURST_STATUS;
        desc.data   = 8'd0;
        desc.status = ST_CONNECTED;
        if (in_fire) begin
            if (!in_kind) begin
                phase_next = PH_METHOD;
                count_next = 5'd0;
                vok_next   = 1'b0;
                code_next  = 8'd0;
                rlen_next  = 5'd0;
                desc_valid = 1'b1;
                desc.burst = BURST_GREET;
            end else begin
                case (phase_reg)
                    PH_METHOD: begin
                        if (count_reg == 5'd0) begin
                            vok_next   = (in_byte == SOCKS_VER);
                            count_next = 5'd1;
                        end else begin
                            desc_valid = 1'b1;
                            if (!vok_reg || (in_byte != METHOD_NONE)) begin
                                phase_next  = PH_FAILED;
                                desc.status = (vok_reg && in_byte == METHOD_NONE_OK) ?
                                              ST_NO_AUTH : ST_BAD_PROTO;
                            end else begin
                                phase_next = PH_REPLY;
                                count_next = 5'd0;
                                vok_next   = 1'b0;
                                rlen_next  = 5'd0;
                                desc.burst = BURST_REQ;
                            end
                        end
                    end
                    PH_REPLY: begin
                        if (count_reg == 5'd0) begin
                            vok_next = (in_byte == SOCKS_VER);
                        end else if (count_reg == 5'd1) begin
                            code_next = in_byte;
                        end else if (count_reg == 5'd3) begin
                            rlen_next = (in_byte == ATYP_IPV4) ? LEN_REPLY_IPV4 :
                                        (in_byte == ATYP_IPV6) ? LEN_REPLY_IPV6 :
                                        LEN_REPLY_OTHER;
                        end
                        count_next = count_inc;
                        // Check the reply once its last byte is in
                        if (count_inc >= REPLY_HDR_LEN && count_inc == rlen_next) begin
                            desc_valid = 1'b1;
                            phase_next = PH_FAILED;
                            if (!vok_next) begin
                                desc.status = ST_BAD_PROTO;
                            end else if (code_next != 8'd0) begin
                                desc.status = (code_next <= MAX_REPLY_CODE) ?
                                              (code_next[3:0] + ST_CODE_BASE) : ST_UNKNOWN;
                            end else if (rlen_next == LEN_REPLY_OTHER) begin
                                desc.status = ST_BAD_PROTO;
                            end else begin
                                phase_next  = PH_CONNECTED;
                                desc.status = ST_CONNECTED;
                            end
                        end
                    end
                    PH_CONNECTED: begin
                        desc_valid = 1'b1;
                        desc.burst = BURST_DATA;
                        desc.data  = in_byte;
                    end
                    default: begin
                        desc_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // Hold protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= 5'd0;
            vok_reg   <= 1'b0;
            code_reg  <= 8'd0;
            rlen_reg  <= 5'd0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            vok_reg   <= vok_next;
            code_reg  <= code_next;
            rlen_reg  <= rlen_next;
        end
    end

    `S5HS_ASSERT_IMPLY(a_failed_silent, in_fire && in_kind && phase_reg == PH_FAILED, !desc_valid, "byte after error produced a result")
    `S5HS_ASSERT_NEXT(a_start_method, in_fire && !in_kind, phase_reg == PH_METHOD && count_reg == 5'd0, "start did not restart the handshake")
    `S5HS_ASSERT_IMPLY(a_req_from_method, desc_valid && desc.burst == BURST_REQ, phase_reg == PH_METHOD, "request burst outside method phase")

endmodule

### hw/rtl/s5hs_emitter.sv
// Burst emitter: walks one descriptor out as a run of result transfers.
`include "socks5_client_handshake_top_defines.svh"

module s5hs_emitter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            desc_valid,
    input  s5hs_pkg::desc_t desc,
    output logic            take,
    input  logic            cfg_ipv6,
    input  logic [63:0]     cfg_upper,
    input  logic [63:0]     cfg_lower,
    input  logic [15:0]     cfg_port,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import s5hs_pkg::*;

    logic       valid_reg, valid_next;
    desc_t      desc_reg, desc_next;
    logic [4:0] idx_reg, idx_next;

    logic [4:0] burst_len;
    logic       at_last;
    logic [7:0] req_byte;
    logic [7:0] out_byte;
    logic [3:0] out_status;
    logic [1:0] out_kind;
    logic [4:0] off_v6u, off_v6l, off_v4;
    logic [2:0] sel_u, sel_l;
    logic [1:0] sel_4;

    // Length of the current burst
    always_comb begin
        case (desc_reg.burst)
            BURST_GREET: burst_len = LEN_GREET;
            BURST_REQ:   burst_len = cfg_ipv6 ? LEN_REQ_IPV6 : LEN_REQ_IPV4;
            default:     burst_len = LEN_SINGLE;
        endcase
    end

    assign at_last = (idx_reg == burst_len - 5'd1);
    assign take    = !valid_reg || (m_tready && at_last);

    // Byte positions inside the address fields, most significant first
    assign off_v6u = idx_reg - 5'd4;
    assign off_v6l = idx_reg - 5'd12;
    assign off_v4  = idx_reg - 5'd4;
    assign sel_u   = 3'd7 - off_v6u[2:0];
    assign sel_l   = 3'd7 - off_v6l[2:0];
    assign sel_4   = 2'd3 - off_v4[1:0];

    // Select the CONNECT request byte at the current position
    always_comb begin
        req_byte = 8'd0;
        if (idx_reg == 5'd0) begin
            req_byte = SOCKS_VER;
        end else if (idx_reg == 5'd1) begin
            req_byte = CMD_CONNECT;
        end else if (idx_reg == 5'd2) begin
            req_byte = 8'd0;
        end else if (idx_reg == 5'd3) begin
            req_byte = cfg_ipv6 ? ATYP_IPV6 : ATYP_IPV4;
        end else if (idx_reg == burst_len - 5'd2) begin
            req_byte = cfg_port[15:8];
        end else if (idx_reg == burst_len - 5'd1) begin
            req_byte = cfg_port[7:0];
        end else if (cfg_ipv6) begin
            if (idx_reg < 5'd12) begin
                req_byte = cfg_upper[{sel_u, 3'b000} +: 8];
            end else begin
                req_byte = cfg_lower[{sel_l, 3'b000} +: 8];
            end
        end else begin
            req_byte = cfg_lower[{1'b0, sel_4, 3'b000} +: 8];
        end
    end

    // Result fields per burst kind
    always_comb begin
        out_kind   = RK_TX;
        out_byte   = 8'd0;
        out_status = ST_CONNECTED;
        case (desc_reg.burst)
            BURST_GREET: begin
                out_byte = (idx_reg == 5'd0) ? SOCKS_VER :
                           (idx_reg == 5'd1) ? CMD_CONNECT : METHOD_NONE;
            end
            BURST_REQ: begin
                out_byte = req_byte;
            end
            BURST_STATUS: begin
                out_kind   = RK_STATUS;
                out_status = desc_reg.status;
            end
            default: begin
                out_kind = RK_DATA;
                out_byte = desc_reg.data;
            end
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, out_status, out_byte};
    assign m_tuser  = out_kind;
    assign m_tlast  = at_last;

    // Load a new burst or advance through the current one
    always_comb begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        idx_next   = idx_reg;
        if (take) begin
            valid_next = desc_valid;
            desc_next  = desc;
            idx_next   = 5'd0;
        end else if (m_tready) begin
            idx_next = idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 5'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    `S5HS_ASSERT_IMPLY(a_idx_in_burst, valid_reg, idx_reg < burst_len, "burst index past its length")
    `S5HS_ASSERT_NEXT(a_load_fresh, take && desc_valid, valid_reg && idx_reg == 5'd0, "burst not loaded at its start")
    `S5HS_ASSERT_IMPLY(a_status_zero_byte, valid_reg && out_kind == RK_STATUS, out_byte == 8'd0 && at_last, "status result carries a byte")

endmodule

### hw/rtl/socks5_client_handshake_top.sv
// A result appears in the cycle after the input transfer that causes it.
// Throughput: one input transfer per cycle while results leave one per cycle; the
// greeting and the CONNECT request stall input until the single result port has
// walked each burst out.
// Reset: aresetn is synchronous, active low; it clears the protocol state,
// the pending burst and all configuration registers.
module socks5_client_handshake_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] status_code, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last
);
    import s5hs_pkg::*;

    logic        ipv6_reg;
    logic [63:0] upper_reg;
    logic [63:0] lower_reg;
    logic [15:0] port_reg;

    logic  in_fire;
    logic  take;
    logic  desc_valid;
    desc_t desc;

    assign cfg_ready = 1'b1;
    assign s_tready  = take;
    assign in_fire   = s_tvalid && take;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipv6_reg  <= 1'b0;
            upper_reg <= 64'd0;
            lower_reg <= 64'd0;
            port_reg  <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IPV6:       ipv6_reg  <= cfg_data[0];
                CFG_ADDR_UPPER: upper_reg <= cfg_data;
                CFG_ADDR_LOWER: lower_reg <= cfg_data;
                CFG_PORT:       port_reg  <= cfg_data[15:0];
                default:        ipv6_reg  <= ipv6_reg;
            endcase
        end
    end

    s5hs_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_kind    (s_tuser),
        .in_byte    (s_tdata),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    s5hs_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .take       (take),
        .cfg_ipv6   (ipv6_reg),
        .cfg_upper  (upper_reg),
        .cfg_lower  (lower_reg),
        .cfg_port   (port_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the SOCKS5 client handshake block.
`timescale 1ns / 100ps

module tb;
    import s5hs_pkg::*;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_RX    = 1'b1;
    localparam logic [7:0] RSV_BYTE = 8'h00;
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned PHASE_ITEMS  = 64;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_STATUS
    } check_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] status;
        logic       last;
    } hs_result_t;

    typedef struct {
        logic       kind;
        logic [7:0] rx;
        check_t     chk;
        logic [3:0] status;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_IPV6;
    logic [63:0] cfg_data = 64'h0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] rx_byte
    logic        s_tuser = 1'b0;     // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [11:8] status_code, [15:12] zero
    logic [1:0]  m_tuser;            // [1:0] result_kind
    logic        m_tlast;

    // Shadow copy of the destination registers
    logic        dest_v6;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [15:0] dest_tcp_port;

    // Predicted protocol state
    phase_t      hs_phase;
    logic [4:0]  rx_count;
    logic        ver_ok;
    logic [7:0]  reply_code;
    logic [4:0]  reply_len;

    hs_result_t  step_out[$];
    hs_result_t  pending_results[$];

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned random_items = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_draw;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;

    // Directed rows; the destination registers hold their reset values here
    directed_row_t directed_rows [0:23] = '{
        '{KIND_RX,    8'hff, CHK_NONE,   ST_CONNECTED},  // byte while idle
        '{KIND_START, 8'h00, CHK_MODEL,  ST_CONNECTED},
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'hff, CHK_STATUS, ST_NO_AUTH},    // no-auth refused
        '{KIND_RX,    8'h00, CHK_NONE,   ST_CONNECTED},  // ignored after error
        '{KIND_START, 8'hff, CHK_MODEL,  ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_STATUS, ST_BAD_PROTO},  // bad method version
        '{KIND_START, 8'h00, CHK_MODEL,  ST_CONNECTED},
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h01, CHK_STATUS, ST_BAD_PROTO},  // unsupported method
        '{KIND_START, 8'h00, CHK_MODEL,  ST_CONNECTED},
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_MODEL,  ST_CONNECTED},  // CONNECT request
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_START, 8'h00, CHK_MODEL,  ST_CONNECTED},  // restart mid-reply
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_MODEL,  ST_CONNECTED},
        '{KIND_RX,    8'h05, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h03, CHK_NONE,   ST_CONNECTED},  // domain-name reply
        '{KIND_RX,    8'h00, CHK_NONE,   ST_CONNECTED},
        '{KIND_RX,    8'h00, CHK_STATUS, ST_BAD_PROTO}
    };

    socks5_client_handshake_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [3:0] status);
        step_out.push_back('{kind: kind, data: data, status: status, last: 1'b0});
    endfunction

    function automatic void mark_failed(logic [3:0] status);
        hs_phase = PH_FAILED;
        emit(RK_STATUS, 8'h00, status);
    endfunction

    function automatic void emit_connect_request();
        emit(RK_TX, SOCKS_VER, ST_CONNECTED);
        emit(RK_TX, CMD_CONNECT, ST_CONNECTED);
        emit(RK_TX, RSV_BYTE, ST_CONNECTED);
        if (dest_v6) begin
            emit(RK_TX, ATYP_IPV6, ST_CONNECTED);
            for (int i = 7; i >= 0; i--) emit(RK_TX, dest_hi[i*8 +: 8], ST_CONNECTED);
            for (int i = 7; i >= 0; i--) emit(RK_TX, dest_lo[i*8 +: 8], ST_CONNECTED);
        end else begin
            emit(RK_TX, ATYP_IPV4, ST_CONNECTED);
            for (int i = 3; i >= 0; i--) emit(RK_TX, dest_lo[i*8 +: 8], ST_CONNECTED);
        end
        emit(RK_TX, dest_tcp_port[15:8], ST_CONNECTED);
        emit(RK_TX, dest_tcp_port[7:0], ST_CONNECTED);
    endfunction

    // Advance the predicted handshake by one input transfer; results land in step_out
    function automatic void handshake_step(logic kind, logic [7:0] rx);
        step_out.delete();
        if (kind == KIND_START) begin
            hs_phase   = PH_METHOD;
            rx_count   = 5'd0;
            ver_ok     = 1'b0;
            reply_code = 8'h00;
            reply_len  = 5'd0;
            emit(RK_TX, SOCKS_VER, ST_CONNECTED);
            emit(RK_TX, CMD_CONNECT, ST_CONNECTED);
            emit(RK_TX, METHOD_NONE, ST_CONNECTED);
        end else begin
            case (hs_phase)
                PH_METHOD: begin
                    if (rx_count == 5'd0) begin
                        ver_ok   = (rx == SOCKS_VER);
                        rx_count = 5'd1;
                    end else if (!ver_ok) begin
                        mark_failed(ST_BAD_PROTO);
                    end else if (rx == METHOD_NONE_OK) begin
                        mark_failed(ST_NO_AUTH);
                    end else if (rx != METHOD_NONE) begin
                        mark_failed(ST_BAD_PROTO);
                    end else begin
                        hs_phase  = PH_REPLY;
                        rx_count  = 5'd0;
                        ver_ok    = 1'b0;
                        reply_len = 5'd0;
                        emit_connect_request();
                    end
                end
                PH_REPLY: begin
                    case (rx_count)
                        5'd0: ver_ok = (rx == SOCKS_VER);
                        5'd1: reply_code = rx;
                        5'd3: reply_len = (rx == ATYP_IPV4) ? LEN_REPLY_IPV4 :
                                          (rx == ATYP_IPV6) ? LEN_REPLY_IPV6 : LEN_REPLY_OTHER;
                        default: ;
                    endcase
                    rx_count = rx_count + 5'd1;
                    // Checks run once the reply is complete: version, code, address type
                    if (rx_count >= REPLY_HDR_LEN && rx_count == reply_len) begin
                        if (!ver_ok)
                            mark_failed(ST_BAD_PROTO);
                        else if (reply_code != 8'h00)
                            mark_failed(reply_code <= MAX_REPLY_CODE ?
                                        ST_CODE_BASE + reply_code[3:0] : ST_UNKNOWN);
                        else if (reply_len == LEN_REPLY_OTHER)
                            mark_failed(ST_BAD_PROTO);
                        else begin
                            hs_phase = PH_CONNECTED;
                            emit(RK_STATUS, 8'h00, ST_CONNECTED);
                        end
                    end
                end
                PH_CONNECTED: emit(RK_DATA, rx, ST_CONNECTED);
                default: ;
            endcase
        end
        if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic void field_ok(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    task automatic check_result();
        hs_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d byte %02h status %0d",
                     $time, m_tuser, m_tdata[7:0], m_tdata[11:8]);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            field_ok("result_kind", want.kind, m_tuser);
            field_ok("out_byte", want.data, m_tdata[7:0]);
            field_ok("status_code", want.status, m_tdata[11:8]);
            field_ok("tdata padding", 0, m_tdata[15:12]);
            field_ok("last", want.last, m_tlast);
        end
    endtask

    // Result sink: check each transfer, then stall a random number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            check_result();
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
            sink_draw = sink_calm ? 0 : $urandom_range(0, 9);
            sink_wait <= sink_draw;
            m_tready  <= (sink_draw == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold one input item until its transfer, then record what it should produce
    task automatic send_item(logic kind, logic [7:0] rx, check_t chk, logic [3:0] status);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        handshake_step(kind, rx);
        case (chk)
            CHK_MODEL: foreach (step_out[i]) pending_results.push_back(step_out[i]);
            CHK_STATUS: pending_results.push_back('{kind: RK_STATUS, data: 8'h00,
                                                     status: status, last: 1'b1});
            default: ;
        endcase
    endtask

    // Hold valid across back-to-back writes; the caller drops it afterwards
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IPV6:       dest_v6       = value[0];
            CFG_ADDR_UPPER: dest_hi       = value;
            CFG_ADDR_LOWER: dest_lo       = value;
            CFG_PORT:       dest_tcp_port = value[15:0];
            default: ;
        endcase
    endtask

    task automatic program_dest(logic v6, logic [63:0] hi, logic [63:0] lo, logic [15:0] tcp);
        write_reg(CFG_IPV6, {63'h0, v6});
        write_reg(CFG_ADDR_UPPER, hi);
        write_reg(CFG_ADDR_LOWER, lo);
        write_reg(CFG_PORT, {48'h0, tcp});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every expected result, plus the block's latency
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One handshake: mostly well formed with random content, sometimes noise or cut short
    task automatic run_session();
        logic [7:0]  seq[$];
        logic [7:0]  atyp;
        int unsigned pick;
        int unsigned cut;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom));
        end else begin
            seq.push_back($urandom_range(0, 15) == 0 ? 8'($urandom) : SOCKS_VER);
            pick = $urandom_range(0, 15);
            seq.push_back(pick == 0 ? METHOD_NONE_OK :
                          pick == 1 ? 8'($urandom) : METHOD_NONE);
            seq.push_back($urandom_range(0, 15) == 0 ? 8'($urandom) : SOCKS_VER);
            pick = $urandom_range(0, 15);
            seq.push_back(pick < 2 ? 8'($urandom_range(9, 255)) :
                          pick < 6 ? 8'($urandom_range(1, 8)) : 8'h00);
            seq.push_back(8'($urandom));
            pick = $urandom_range(0, 9);
            atyp = pick < 4 ? ATYP_IPV4 : pick < 8 ? ATYP_IPV6 : 8'($urandom);
            seq.push_back(atyp);
            repeat (atyp == ATYP_IPV4 ? 6 : atyp == ATYP_IPV6 ? 18 : 2)
                seq.push_back(8'($urandom));
            repeat ($urandom_range(0, 6)) seq.push_back(8'($urandom));
        end
        // Occasionally cut the exchange short; the next start restarts it
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, seq.size() - 1);
            while (seq.size() > cut) void'(seq.pop_back());
        end
        send_item(KIND_START, 8'($urandom), CHK_MODEL, ST_CONNECTED);
        foreach (seq[i]) send_item(KIND_RX, seq[i], CHK_MODEL, ST_CONNECTED);
        random_items += seq.size() + 1;
    endtask

    initial begin
        int unsigned phase_start;
        dest_v6       = 1'b0;
        dest_hi       = 64'h0;
        dest_lo       = 64'h0;
        dest_tcp_port = 16'h0;
        hs_phase      = PH_IDLE;
        rx_count      = 5'd0;
        ver_ok        = 1'b0;
        reply_code    = 8'h00;
        reply_len     = 5'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].rx,
                      directed_rows[i].chk, directed_rows[i].status);

        // Random phases, each under its own destination setting
        for (int p = 0; random_items < RANDOM_ITEMS; p++) begin
            drain_results();
            case (p)
                0: program_dest(1'b1, '1, '1, 16'hffff);
                1: program_dest(1'b0, '0, '0, 16'h0000);
                2: program_dest(1'b0, '1, {$urandom, $urandom}, 16'($urandom));
                default: program_dest(1'($urandom), {$urandom, $urandom},
                                      {$urandom, $urandom}, 16'($urandom));
            endcase
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS && random_items < RANDOM_ITEMS)
                run_session();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/s5hs_pkg.sv
hw/rtl/s5hs_parser.sv
hw/rtl/s5hs_emitter.sv
hw/rtl/socks5_client_handshake_top.sv
sim/tb.sv
